[hdl/h2r_pkg.sv]
package h2r_pkg;

    localparam int CH_W  = 17;
    localparam int HUE_W = 16;
    localparam int REM_W = 13;

    // one sextant is 15 << 9 hue units
    localparam int HUE_SEXTANT = 7680;
    localparam int SEXT_SHIFT  = 9;
    localparam int SEXT_ODD    = 15;
    localparam int SEXT_COUNT  = 6;

    localparam logic [HUE_W-1:0] HUE_FULL = 16'd46080;

    typedef enum logic [1:0] {
        MODE_CALC,
        MODE_GRAY,
        MODE_BAD,
        MODE_BLACK
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic [2:0] sext;
        logic       dneg;
    } ctrl_t;

    typedef struct packed {
        logic [2:0]       sext;
        logic [REM_W-1:0] rem;
    } hue_split_t;

    // Sextant and remainder of a hue below a full turn
    function automatic hue_split_t hue_split(input logic [HUE_W-1:0] h);
        hue_split_t       res;
        logic [HUE_W-1:0] base;
        res.sext = '0;
        base     = '0;
        for (int i = 1; i < SEXT_COUNT; i++)
        begin
            if (h >= HUE_W'(i * HUE_SEXTANT))
            begin
                res.sext = 3'(i);
                base     = HUE_W'(i * HUE_SEXTANT);
            end
        end
        res.rem = REM_W'(h - base);
        return res;
    endfunction

endpackage

[hdl/h2r_front.sv]
module h2r_front
    import h2r_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [HUE_W-1:0]                  hue,
    input  logic                              hue_defined,
    input  logic [CH_W-1:0]                   saturation,
    input  logic [CH_W-1:0]                   lightness,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [((2*CH_W-FRAC_BITS > CH_W) ? 2*CH_W-FRAC_BITS : CH_W)+1:0] v,
    output logic signed [((2*CH_W-FRAC_BITS > CH_W) ? 2*CH_W-FRAC_BITS : CH_W)+1:0] m,
    output logic [((2*CH_W-FRAC_BITS > CH_W) ? 2*CH_W-FRAC_BITS : CH_W):0]          dmag,
    output logic [REM_W-1:0]                  rem,
    output ctrl_t                             ctrl
);

    localparam int PRW = 2 * CH_W - FRAC_BITS;
    localparam int XW  = (PRW > CH_W) ? PRW : CH_W;
    localparam int VW  = XW + 2;
    localparam int LW  = (FRAC_BITS > CH_W) ? FRAC_BITS : CH_W;
    localparam logic [LW-1:0] HALF = LW'(1) << (FRAC_BITS - 1);

    // stage A: product of lightness and saturation, hue split
    logic                  a_valid_reg;
    logic [2*CH_W-1:0]     a_prod_reg;
    logic [CH_W-1:0]       a_l_reg;
    logic [CH_W-1:0]       a_s_reg;
    logic [REM_W-1:0]      a_rem_reg;
    ctrl_t                 a_ctrl_reg;
    ctrl_t                 a_ctrl_next;
    hue_split_t            split;
    logic [HUE_W-1:0]      h_fold;
    logic                  a_en;

    // stage B: maximum, minimum and spread
    logic                  b_valid_reg;
    logic signed [VW-1:0]  b_v_reg;
    logic signed [VW-1:0]  b_m_reg;
    logic [XW:0]           b_dmag_reg;
    logic [REM_W-1:0]      b_rem_reg;
    ctrl_t                 b_ctrl_reg;
    logic signed [VW-1:0]  b_v_next;
    logic signed [VW-1:0]  b_m_next;
    logic [XW:0]           b_dmag_next;
    ctrl_t                 b_ctrl_next;
    logic                  b_en;

    logic [PRW-1:0]        p;
    logic signed [XW:0]    vl;
    logic signed [XW:0]    vl_abs;
    logic signed [VW-1:0]  l_ext;
    logic signed [VW-1:0]  v_calc;

    assign b_en     = !b_valid_reg || !out_stall;
    assign a_en     = !a_valid_reg || b_en;
    assign in_stall = !a_en;

    always_comb
    begin
        h_fold            = (hue == HUE_FULL) ? '0 : hue;
        split             = hue_split(h_fold);
        a_ctrl_next.sext  = split.sext;
        a_ctrl_next.dneg  = 1'b0;
        if (saturation == '0)
            a_ctrl_next.mode = hue_defined ? MODE_BAD : MODE_GRAY;
        else if (hue_defined && (hue <= HUE_FULL))
            a_ctrl_next.mode = MODE_CALC;
        else
            a_ctrl_next.mode = MODE_BLACK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (a_en)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (a_en && in_valid)
        begin
            a_prod_reg <= (2*CH_W)'(lightness) * (2*CH_W)'(saturation);
            a_l_reg    <= lightness;
            a_s_reg    <= saturation;
            a_rem_reg  <= split.rem;
            a_ctrl_reg <= a_ctrl_next;
        end
    end

    // low half: v = l + l*s, high half: v = l + s - l*s
    always_comb
    begin
        p = a_prod_reg[2*CH_W-1:FRAC_BITS];
        if (LW'(a_l_reg) <= HALF)
            vl = $signed((XW+1)'(p));
        else
            vl = $signed((XW+1)'(a_s_reg)) - $signed((XW+1)'(p));
        vl_abs      = vl[XW] ? -vl : vl;
        l_ext       = $signed(VW'(a_l_reg));
        v_calc      = l_ext + VW'(vl);
        b_m_next    = l_ext - VW'(vl);
        b_dmag_next = {vl_abs[XW-1:0], 1'b0};
        b_ctrl_next      = a_ctrl_reg;
        b_ctrl_next.dneg = vl[XW];
        if ((a_ctrl_reg.mode == MODE_CALC) && (v_calc <= 0))
            b_ctrl_next.mode = MODE_BLACK;
        b_v_next = (a_ctrl_reg.mode == MODE_GRAY) ? l_ext : v_calc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (b_en)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b_en && a_valid_reg)
        begin
            b_v_reg    <= b_v_next;
            b_m_reg    <= b_m_next;
            b_dmag_reg <= b_dmag_next;
            b_rem_reg  <= a_rem_reg;
            b_ctrl_reg <= b_ctrl_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign v         = b_v_reg;
    assign m         = b_m_reg;
    assign dmag      = b_dmag_reg;
    assign rem       = b_rem_reg;
    assign ctrl      = b_ctrl_reg;

endmodule

[hdl/h2r_mix.sv]
module h2r_mix
    import h2r_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [((2*CH_W-FRAC_BITS > CH_W) ? 2*CH_W-FRAC_BITS : CH_W)+1:0] v_in,
    input  logic signed [((2*CH_W-FRAC_BITS > CH_W) ? 2*CH_W-FRAC_BITS : CH_W)+1:0] m_in,
    input  logic [((2*CH_W-FRAC_BITS > CH_W) ? 2*CH_W-FRAC_BITS : CH_W):0]          dmag,
    input  logic [REM_W-1:0]                  rem,
    input  ctrl_t                             ctrl_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [((2*CH_W-FRAC_BITS > CH_W) ? 2*CH_W-FRAC_BITS : CH_W)+1:0] v_out,
    output logic signed [((2*CH_W-FRAC_BITS > CH_W) ? 2*CH_W-FRAC_BITS : CH_W)+1:0] m_out,
    output logic [((2*CH_W-FRAC_BITS > CH_W) ? 2*CH_W-FRAC_BITS : CH_W):0]          q,
    output ctrl_t                             ctrl_out
);

    localparam int PRW = 2 * CH_W - FRAC_BITS;
    localparam int XW  = (PRW > CH_W) ? PRW : CH_W;
    localparam int VW  = XW + 2;
    localparam int MW  = XW + 1 + REM_W + 1;
    localparam int ZW  = MW - SEXT_SHIFT;
    localparam int RS  = ZW + 4;
    localparam int RW  = ZW + 1;
    localparam int QW  = XW + 1;
    localparam logic [63:0] RECIP64 =
        ((64'd1 << RS) + 64'(SEXT_ODD) - 64'd1) / 64'(SEXT_ODD);
    localparam logic [RW-1:0] RECIP = RW'(RECIP64);

    // stage C: spread times hue remainder, scaled down by 512
    logic                  c_valid_reg;
    logic [ZW-1:0]         c_z_reg;
    logic signed [VW-1:0]  c_v_reg;
    logic signed [VW-1:0]  c_m_reg;
    ctrl_t                 c_ctrl_reg;
    logic [MW-1:0]         mag;
    logic [ZW-1:0]         c_z_next;
    logic                  c_en;

    // stage D: divide by 15 through the reciprocal
    logic                  d_valid_reg;
    logic [QW-1:0]         d_q_reg;
    logic signed [VW-1:0]  d_v_reg;
    logic signed [VW-1:0]  d_m_reg;
    ctrl_t                 d_ctrl_reg;
    logic [ZW+RW-1:0]      qprod;
    logic [QW-1:0]         d_q_next;
    logic                  d_en;

    assign d_en     = !d_valid_reg || !out_stall;
    assign c_en     = !c_valid_reg || d_en;
    assign in_stall = !c_en;

    // a negative spread rounds the magnitude up, so bias it before the divide
    always_comb
    begin
        mag = MW'(dmag) * MW'(rem)
            + (ctrl_in.dneg ? MW'(HUE_SEXTANT - 1) : MW'(0));
        c_z_next = mag[MW-1:SEXT_SHIFT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (c_en)
            c_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (c_en && in_valid)
        begin
            c_z_reg    <= c_z_next;
            c_v_reg    <= v_in;
            c_m_reg    <= m_in;
            c_ctrl_reg <= ctrl_in;
        end
    end

    always_comb
    begin
        qprod    = (ZW+RW)'(c_z_reg) * (ZW+RW)'(RECIP);
        d_q_next = qprod[RS +: QW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (d_en)
            d_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (d_en && c_valid_reg)
        begin
            d_q_reg    <= d_q_next;
            d_v_reg    <= c_v_reg;
            d_m_reg    <= c_m_reg;
            d_ctrl_reg <= c_ctrl_reg;
        end
    end

    assign out_valid = d_valid_reg;
    assign q         = d_q_reg;
    assign v_out     = d_v_reg;
    assign m_out     = d_m_reg;
    assign ctrl_out  = d_ctrl_reg;

endmodule

[hdl/h2r_out.sv]
module h2r_out
    import h2r_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [((2*CH_W-FRAC_BITS > CH_W) ? 2*CH_W-FRAC_BITS : CH_W)+1:0] v,
    input  logic signed [((2*CH_W-FRAC_BITS > CH_W) ? 2*CH_W-FRAC_BITS : CH_W)+1:0] m,
    input  logic [((2*CH_W-FRAC_BITS > CH_W) ? 2*CH_W-FRAC_BITS : CH_W):0]          q,
    input  ctrl_t                             ctrl,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [CH_W-1:0]                   red,
    output logic [CH_W-1:0]                   green,
    output logic [CH_W-1:0]                   blue,
    output logic                              bad_input
);

    localparam int PRW = 2 * CH_W - FRAC_BITS;
    localparam int XW  = (PRW > CH_W) ? PRW : CH_W;
    localparam int SW  = XW + 3;
    localparam logic [CH_W-1:0] CH_TOP =
        (FRAC_BITS >= CH_W) ? {CH_W{1'b1}} : CH_W'(64'd1 << FRAC_BITS);
    localparam logic signed [SW-1:0] TOP_S = $signed(SW'(CH_TOP));

    logic                 o_valid_reg;
    logic [CH_W-1:0]      red_reg;
    logic [CH_W-1:0]      green_reg;
    logic [CH_W-1:0]      blue_reg;
    logic                 bad_reg;
    logic [CH_W-1:0]      red_next;
    logic [CH_W-1:0]      green_next;
    logic [CH_W-1:0]      blue_next;
    logic                 o_en;

    logic signed [SW-1:0] kk;
    logic signed [SW-1:0] k;
    logic signed [SW-1:0] v_e;
    logic signed [SW-1:0] m_e;
    logic signed [SW-1:0] mid1;
    logic signed [SW-1:0] mid2;
    logic signed [SW-1:0] r_c;
    logic signed [SW-1:0] g_c;
    logic signed [SW-1:0] b_c;

    function automatic logic [CH_W-1:0] clamp(input logic signed [SW-1:0] x);
        logic [CH_W-1:0] res;
        if (x < 0)
            res = '0;
        else if (x > TOP_S)
            res = CH_TOP;
        else
            res = x[CH_W-1:0];
        return res;
    endfunction

    assign o_en     = !o_valid_reg || !out_stall;
    assign in_stall = !o_en;

    always_comb
    begin
        kk   = $signed(SW'(q));
        k    = ctrl.dneg ? -kk : kk;
        v_e  = SW'(v);
        m_e  = SW'(m);
        mid1 = m_e + k;
        mid2 = v_e - k;
        case (ctrl.sext)
            3'd0:
            begin
                r_c = v_e;  g_c = mid1; b_c = m_e;
            end
            3'd1:
            begin
                r_c = mid2; g_c = v_e;  b_c = m_e;
            end
            3'd2:
            begin
                r_c = m_e;  g_c = v_e;  b_c = mid1;
            end
            3'd3:
            begin
                r_c = m_e;  g_c = mid2; b_c = v_e;
            end
            3'd4:
            begin
                r_c = mid1; g_c = m_e;  b_c = v_e;
            end
            default:
            begin
                r_c = v_e;  g_c = m_e;  b_c = mid2;
            end
        endcase
        case (ctrl.mode)
            MODE_CALC:
            begin
                red_next   = clamp(r_c);
                green_next = clamp(g_c);
                blue_next  = clamp(b_c);
            end
            MODE_GRAY:
            begin
                red_next   = clamp(v_e);
                green_next = clamp(v_e);
                blue_next  = clamp(v_e);
            end
            default:
            begin
                red_next   = '0;
                green_next = '0;
                blue_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (o_en)
            o_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (o_en && in_valid)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            bad_reg   <= (ctrl.mode == MODE_BAD);
        end
    end

    assign out_valid = o_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign bad_input = bad_reg;

endmodule

[hdl/hsl_to_rgb_convert.sv]
// HSL to RGB pixel converter, five register stages.
// Throughput: one pixel per clock while out_stall is low; under a stall,
// a full stage holds only if every stage after it is full as well.
// Reset (rst_n low, asynchronous) empties the pipeline; nothing else is kept.
module hsl_to_rgb_convert
    import h2r_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [HUE_W-1:0]  hue,
    input  logic              hue_defined,
    input  logic [CH_W-1:0]   saturation,
    input  logic [CH_W-1:0]   lightness,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CH_W-1:0]   red,
    output logic [CH_W-1:0]   green,
    output logic [CH_W-1:0]   blue,
    output logic              bad_input
);

    localparam int PRW = 2 * CH_W - FRAC_BITS;
    localparam int XW  = (PRW > CH_W) ? PRW : CH_W;
    localparam int VW  = XW + 2;

    logic                 f_valid;
    logic                 f_stall;
    logic signed [VW-1:0] f_v;
    logic signed [VW-1:0] f_m;
    logic [XW:0]          f_dmag;
    logic [REM_W-1:0]     f_rem;
    ctrl_t                f_ctrl;

    logic                 x_valid;
    logic                 x_stall;
    logic signed [VW-1:0] x_v;
    logic signed [VW-1:0] x_m;
    logic [XW:0]          x_q;
    ctrl_t                x_ctrl;

    h2r_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .hue         (hue),
        .hue_defined (hue_defined),
        .saturation  (saturation),
        .lightness   (lightness),
        .out_valid   (f_valid),
        .out_stall   (f_stall),
        .v           (f_v),
        .m           (f_m),
        .dmag        (f_dmag),
        .rem         (f_rem),
        .ctrl        (f_ctrl)
    );

    h2r_mix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_stall  (f_stall),
        .v_in      (f_v),
        .m_in      (f_m),
        .dmag      (f_dmag),
        .rem       (f_rem),
        .ctrl_in   (f_ctrl),
        .out_valid (x_valid),
        .out_stall (x_stall),
        .v_out     (x_v),
        .m_out     (x_m),
        .q         (x_q),
        .ctrl_out  (x_ctrl)
    );

    h2r_out #(
        .FRAC_BITS (FRAC_BITS)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (x_valid),
        .in_stall  (x_stall),
        .v         (x_v),
        .m         (x_m),
        .q         (x_q),
        .ctrl      (x_ctrl),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .bad_input (bad_input)
    );

endmodule
